// ===== hw/rtl/gts_pkg.sv =====
package gts_pkg;

  localparam int NUM_STATES = 16;
  localparam int MAX_TRANS  = 8;
  localparam int MAX_CONDS  = 16;

  localparam int STATE_W = 4;
  localparam int IDX_W   = 3;
  localparam int KIND_W  = 3;
  localparam int KEY_W   = 64;
  localparam int MIX_W   = 16;

  localparam int NSLOTS  = NUM_STATES * MAX_TRANS;
  localparam int SLOT_AW = $clog2(NSLOTS);
  localparam int TCNT_W  = $clog2(MAX_TRANS + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD    = 3'd0,
    KIND_SET     = 3'd1,
    KIND_CLEAR   = 3'd2,
    KIND_UPDATE  = 3'd3,
    KIND_RESTART = 3'd4
  } kind_e;

  typedef struct packed {
    logic               valid;
    logic [MIX_W-1:0]   mix;
    logic               auto_clear;
    logic               at_end;
    logic [STATE_W-1:0] target;
  } slot_info_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    slot_info_t       info;
  } slot_entry_t;

  localparam int SLOT_W = $bits(slot_entry_t);

  typedef struct packed {
    logic set;
    logic clear;
  } cond_op_t;

  typedef struct packed {
    logic hit;
    logic full;
  } cond_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_DONE
  } seq_state_e;

endpackage

// ===== hw/rtl/gts_ram.sv =====
module gts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== hw/rtl/gts_cond.sv =====
module gts_cond (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  gts_pkg::cond_op_t         op_i,
  input  logic [gts_pkg::KEY_W-1:0] key_i,
  output gts_pkg::cond_stat_t       stat_o
);
  import gts_pkg::*;

  logic [KEY_W-1:0]     keys_q [MAX_CONDS];
  logic [MAX_CONDS-1:0] used_q, used_d;
  logic [MAX_CONDS-1:0] match;
  logic [MAX_CONDS-1:0] free_oh;
  logic                 insert;

  always_comb begin
    for (int i = 0; i < MAX_CONDS; i++) begin
      match[i] = used_q[i] && (keys_q[i] == key_i);
    end
  end

  // lowest free entry, one-hot; zero when the set is full
  assign free_oh = ~used_q & (used_q + 1'b1);

  assign stat_o.hit  = |match;
  assign stat_o.full = &used_q;
  assign insert      = op_i.set && !stat_o.hit;

  always_comb begin
    used_d = used_q;
    priority if (op_i.clear) begin
      used_d = used_q & ~match;
    end else if (insert) begin
      used_d = used_q | free_oh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_CONDS; i++) begin
      if (insert && free_oh[i]) begin
        keys_q[i] <= key_i;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_unique_keys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("condition key held in more than one entry");

  a_set_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i.set && !op_i.clear && !stat_o.hit && !stat_o.full) |=>
      ($countones(used_q) == $past($countones(used_q)) + 1))
    else $error("new condition not added to the set");

  a_clear_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i.clear && stat_o.hit) |=>
      ($countones(used_q) == $past($countones(used_q)) - 1))
    else $error("active condition not removed");
`endif

endmodule

// ===== hw/rtl/guarded_transition_sequencer.sv =====
// Table-driven state sequencer. Raise start for one item while busy is low; the
// item is taken at that edge and busy stays high until its result is out. Every
// item gives exactly one result, shown for a single cycle with done_o high; the
// receiver cannot stall it, so sample it in that cycle. Load, set, clear, restart
// and unknown kinds go from accept through execute and done back to idle. An update
// reads the current state's slots from the slot RAM one per cycle, each checked in
// parallel against all active conditions, and stops at the first slot that fires
// or after the last slot when none does.
// The initial-state register may be written at any time the block is idle.
module guarded_transition_sequencer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [gts_pkg::STATE_W-1:0] cfg_data_i,
  input  logic [gts_pkg::KIND_W-1:0]  kind_i,
  input  logic [gts_pkg::STATE_W-1:0] slot_state_i,
  input  logic [gts_pkg::IDX_W-1:0]   slot_index_i,
  input  logic [gts_pkg::KEY_W-1:0]   condition_key_i,
  input  logic [gts_pkg::STATE_W-1:0] target_state_i,
  input  logic                        at_end_i,
  input  logic                        auto_clear_i,
  input  logic [gts_pkg::MIX_W-1:0]   blend_time_i,
  input  logic                        slot_valid_i,
  input  logic                        layer_finished_i,
  output logic                        done_o,
  output logic                        entered_o,
  output logic                        notify_o,
  output logic [gts_pkg::STATE_W-1:0] from_state_o,
  output logic [gts_pkg::STATE_W-1:0] to_state_o,
  output logic [gts_pkg::MIX_W-1:0]   mix_out_o,
  output logic [gts_pkg::STATE_W-1:0] now_state_o,
  output logic                        status_o
);
  import gts_pkg::*;

  seq_state_e state_q, state_d;

  logic [STATE_W-1:0] init_q;
  logic [STATE_W-1:0] cur_q;

  logic [KIND_W-1:0]  kind_q;
  logic [STATE_W-1:0] slot_state_q;
  logic [IDX_W-1:0]   slot_index_q;
  logic [KEY_W-1:0]   key_q;
  logic [STATE_W-1:0] target_q;
  logic               at_end_q;
  logic               auto_clear_q;
  logic [MIX_W-1:0]   blend_q;
  logic               slot_valid_q;
  logic               fin_q;

  logic [TCNT_W-1:0]  rd_idx_q;
  logic               last_q;
  logic [NSLOTS-1:0]  seen_q;
  logic               seen_rd_q;

  logic               entered_q, notify_q, status_q;
  logic [STATE_W-1:0] from_q, to_q;
  logic [MIX_W-1:0]   mix_q;

  logic               accept;
  logic               load_ok;
  logic [SLOT_AW-1:0] load_addr, walk_addr, ram_addr;
  logic               ram_we;
  logic               issue;
  logic               fire;
  logic               walk_end;
  logic [STATE_W-1:0] start_state;
  logic [SLOT_W-1:0]  ram_rdata;
  slot_entry_t        rd_entry, wr_entry;
  logic [KEY_W-1:0]   cond_key;
  cond_op_t           cond_op;
  cond_stat_t         cond_stat;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  assign load_ok = (32'(slot_state_q) < NUM_STATES) && (32'(slot_index_q) < MAX_TRANS) &&
                   (32'(target_q) < NUM_STATES);
  assign load_addr = SLOT_AW'(32'(slot_state_q) * MAX_TRANS + 32'(slot_index_q));
  assign walk_addr = SLOT_AW'(32'(cur_q) * MAX_TRANS + 32'(rd_idx_q));
  assign start_state = (32'(init_q) < NUM_STATES) ? init_q : '0;

  assign wr_entry.key             = key_q;
  assign wr_entry.info.valid      = slot_valid_q;
  assign wr_entry.info.mix        = blend_q;
  assign wr_entry.info.auto_clear = auto_clear_q;
  assign wr_entry.info.at_end     = at_end_q;
  assign wr_entry.info.target     = target_q;
  assign rd_entry                 = slot_entry_t'(ram_rdata);

  gts_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(NSLOTS)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(wr_entry),
    .rdata_o(ram_rdata)
  );

  gts_cond u_cond (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .op_i  (cond_op),
    .key_i (cond_key),
    .stat_o(cond_stat)
  );

  // a slot never loaded reads as empty
  assign fire = (state_q == ST_WALK) && seen_rd_q && rd_entry.info.valid && cond_stat.hit &&
                (!rd_entry.info.at_end || fin_q);
  assign walk_end = fire || last_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start) state_d = ST_EXEC;
      ST_EXEC: state_d = (kind_q == KIND_UPDATE) ? ST_WALK : ST_DONE;
      ST_WALK: if (walk_end) state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy          = 1'b1;
    done_o        = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = walk_addr;
    issue         = 1'b0;
    cond_key      = key_q;
    cond_op.set   = 1'b0;
    cond_op.clear = 1'b0;
    unique case (state_q)
      ST_IDLE: busy = 1'b0;
      ST_EXEC: begin
        if (kind_q == KIND_LOAD) begin
          ram_addr = load_addr;
          ram_we   = load_ok;
        end
        issue         = (kind_q == KIND_UPDATE);
        cond_op.set   = (kind_q == KIND_SET);
        cond_op.clear = (kind_q == KIND_CLEAR);
      end
      ST_WALK: begin
        issue         = (32'(rd_idx_q) < MAX_TRANS);
        cond_key      = rd_entry.key;
        cond_op.clear = fire && rd_entry.info.auto_clear;
      end
      ST_DONE: done_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      init_q  <= '0;
      cur_q   <= '0;
      seen_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        init_q <= cfg_data_i;
      end
      if (ram_we) begin
        seen_q[load_addr] <= 1'b1;
      end
      if (state_q == ST_EXEC && kind_q == KIND_RESTART) begin
        cur_q <= start_state;
      end else if (fire) begin
        cur_q <= rd_entry.info.target;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q       <= kind_i;
      slot_state_q <= slot_state_i;
      slot_index_q <= slot_index_i;
      key_q        <= condition_key_i;
      target_q     <= target_state_i;
      at_end_q     <= at_end_i;
      auto_clear_q <= auto_clear_i;
      blend_q      <= blend_time_i;
      slot_valid_q <= slot_valid_i;
      fin_q        <= layer_finished_i;
      rd_idx_q     <= '0;
    end else if (issue) begin
      rd_idx_q <= rd_idx_q + 1'b1;
    end
    // flags are registered like the RAM read, so they line up with its data
    seen_rd_q <= seen_q[ram_addr];
    last_q    <= (32'(rd_idx_q) == MAX_TRANS - 1);

    if (state_q == ST_EXEC) begin
      entered_q <= (kind_q == KIND_RESTART);
      notify_q  <= 1'b0;
      from_q    <= (kind_q == KIND_RESTART) ? cur_q : '0;
      to_q      <= (kind_q == KIND_RESTART) ? start_state : '0;
      mix_q     <= '0;
      status_q  <= (kind_q == KIND_SET) && !cond_stat.hit && cond_stat.full;
    end else if (fire) begin
      entered_q <= 1'b1;
      notify_q  <= 1'b1;
      from_q    <= cur_q;
      to_q      <= rd_entry.info.target;
      mix_q     <= rd_entry.info.mix;
    end
  end

  assign entered_o    = entered_q;
  assign notify_o     = notify_q;
  assign from_state_o = from_q;
  assign to_state_o   = to_q;
  assign mix_out_o    = mix_q;
  assign now_state_o  = cur_q;
  assign status_o     = status_q;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("item transfer did not raise busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_notify_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && notify_o) |-> entered_o)
    else $error("transition reported without a state entry");

  a_entry_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && entered_o) |-> (now_state_o == to_state_o))
    else $error("current state differs from entered state");
`endif

endmodule
